// ----- hw/rtl/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the scene change scorer.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SAD_W       = 43;
    localparam int SCORE_W     = 23;
    localparam int CNT_CFG_W   = 28;
    localparam int BITS_CFG_W  = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 28;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SAD_W-1:0] SAD_MAX = {SAD_W{1'b1}};

    localparam logic [BITS_CFG_W-1:0] MIN_BITS = 5'd8;
    localparam logic [BITS_CFG_W-1:0] MAX_BITS = 5'd16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_CHANGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 2'd3;

    localparam logic [SCORE_W-1:0]    THRESHOLD_RST    = 23'd655360;
    localparam logic                  PASS_CHANGES_RST = 1'b0;
    localparam logic [CNT_CFG_W-1:0]  SAMPLE_COUNT_RST = 28'd2073600;
    localparam logic [BITS_CFG_W-1:0] SAMPLE_BITS_RST  = 5'd8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] prev_sample;
        logic [SAMPLE_W-1:0] cur_sample;
        logic                last_sample;
    } sample_t;

    typedef struct packed {
        logic [SCORE_W-1:0] mean_diff;
        logic [SCORE_W-1:0] score;
        logic               scene_change;
        logic               keep_frame;
    } result_t;

    typedef struct packed {
        logic [SCORE_W-1:0]    threshold;
        logic                  pass_only_changes;
        logic [CNT_CFG_W-1:0]  sample_count;
        logic [BITS_CFG_W-1:0] sample_bits;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_CHECK,
        S_DIV,
        S_SCORE,
        S_EMIT
    } back_state_t;

endpackage

// ----- hw/rtl/scs_sample_if.sv -----
// ----------------------------------------------------------------------------
// scs_sample_if
// Valid/ready channel carrying one pair of co-located samples per item.
// ----------------------------------------------------------------------------
interface scs_sample_if;
    import scs_pkg::*;

    logic    valid;
    logic    ready;
    sample_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/scs_result_if.sv -----
// ----------------------------------------------------------------------------
// scs_result_if
// Valid/ready channel carrying one frame score per item.
// ----------------------------------------------------------------------------
interface scs_result_if;
    import scs_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/scene_change_score.sv -----
// ----------------------------------------------------------------------------
// scene_change_score
// Scene change detector: per-frame mean absolute difference and score.
// ----------------------------------------------------------------------------
// samples: one item per co-located pair of previous and current frame
// samples, all planes in one stream; last_sample marks the end of a frame.
// Samples are taken one per cycle; ready drops only when two finished
// frame sums are still waiting for the scoring unit.
// results: one item per frame. The scoring unit divides with one quotient
// bit per cycle; the first frame after reset skips the division and
// scores 0. The scoring unit takes the next frame sum only after it has
// handed the last result to the output register; shorter frames back up
// into the two-entry queue. The result sits in an output register, so a
// stalled receiver holds only the scoring unit; sample intake goes on
// until the queue fills.
// Configuration writes are registered; change them only while no frame is
// in flight. Reset clears the sum, the previous frame mean and loads the
// register defaults.
// ----------------------------------------------------------------------------
module scene_change_score #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 27
) (
    input  logic                           clk,
    input  logic                           rst_n,
    scs_sample_if.sink                     samples,
    scs_result_if.source                   results,
    input  logic                           cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import scs_pkg::*;

    cfg_t             cfg_reg;
    logic             queue_full;
    logic             push;
    logic [SAD_W-1:0] push_sad;
    logic             pop;
    logic             head_valid;
    logic [SAD_W-1:0] head_sad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold         <= THRESHOLD_RST;
            cfg_reg.pass_only_changes <= PASS_CHANGES_RST;
            cfg_reg.sample_count      <= SAMPLE_COUNT_RST;
            cfg_reg.sample_bits       <= SAMPLE_BITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:    cfg_reg.threshold         <= cfg_data[SCORE_W-1:0];
                REG_PASS_CHANGES: cfg_reg.pass_only_changes <= cfg_data[0];
                REG_SAMPLE_COUNT: cfg_reg.sample_count      <= cfg_data[CNT_CFG_W-1:0];
                REG_SAMPLE_BITS:  cfg_reg.sample_bits       <= cfg_data[BITS_CFG_W-1:0];
                default:          cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    scs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push),
        .push_sad   (push_sad)
    );

    scs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_sad   (push_sad),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_sad   (head_sad)
    );

    scs_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_sad   (head_sad),
        .pop        (pop),
        .results    (results)
    );

endmodule

// ----- hw/rtl/scs_front.sv -----
// ----------------------------------------------------------------------------
// scs_front
// Sample intake: saturating sum of absolute differences, one frame total
// pushed to the queue on the last sample.
// ----------------------------------------------------------------------------
module scs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    scs_sample_if.sink               samples,
    input  logic                     queue_full,
    output logic                     push,
    output logic [scs_pkg::SAD_W-1:0] push_sad
);
    import scs_pkg::*;

    logic [SAD_W-1:0]    acc_reg;
    logic [SAD_W-1:0]    acc_next;
    logic [SAMPLE_W-1:0] abs_diff;
    logic [SAD_W:0]      sum;
    logic [SAD_W-1:0]    sum_sat;
    logic                take;

    assign samples.ready = !queue_full;
    assign take          = samples.valid && samples.ready;

    always_comb
    begin
        if (samples.data.prev_sample >= samples.data.cur_sample)
        begin
            abs_diff = samples.data.prev_sample - samples.data.cur_sample;
        end
        else
        begin
            abs_diff = samples.data.cur_sample - samples.data.prev_sample;
        end
        sum     = {1'b0, acc_reg} + (SAD_W + 1)'(abs_diff);
        sum_sat = sum[SAD_W] ? SAD_MAX : sum[SAD_W-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (take)
        begin
            acc_next = samples.data.last_sample ? '0 : sum_sat;
        end
    end

    assign push     = take && samples.data.last_sample;
    assign push_sad = sum_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- hw/rtl/scs_queue.sv -----
// ----------------------------------------------------------------------------
// scs_queue
// Short queue of frame sums between sample intake and the scoring unit.
// ----------------------------------------------------------------------------
module scs_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [scs_pkg::SAD_W-1:0] push_sad,
    input  logic                      pop,
    output logic                      full,
    output logic                      head_valid,
    output logic [scs_pkg::SAD_W-1:0] head_sad
);
    import scs_pkg::*;

    logic [SAD_W-1:0]  mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_sad   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_sad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/scs_back.sv -----
// ----------------------------------------------------------------------------
// scs_back
// Frame scoring: mean absolute frame difference by restoring division,
// score against the previous frame, threshold and output register.
// ----------------------------------------------------------------------------
module scs_back #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 27
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  scs_pkg::cfg_t             cfg,
    input  logic                      head_valid,
    input  logic [scs_pkg::SAD_W-1:0] head_sad,
    output logic                      pop,
    scs_result_if.source              results
);
    import scs_pkg::*;

    localparam int NUM_W  = SAD_W + 7;
    localparam int CNT_W  = COUNT_BITS + 1;
    localparam int CMPC_W = ((COUNT_BITS > CNT_CFG_W) ? COUNT_BITS : CNT_CFG_W) + 1;
    localparam int DEN_W  = CNT_W + SAMPLE_W;
    localparam int CMP_W  = (NUM_W > DEN_W + 7) ? NUM_W : DEN_W + 7;
    localparam int Q_W    = 7 + FRAC_BITS;
    localparam int MW     = (Q_W > SCORE_W) ? Q_W : SCORE_W;
    localparam int STEP_W = $clog2(Q_W + 1);

    localparam logic [Q_W-1:0] HUNDRED_Q = Q_W'(100 << FRAC_BITS);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [SAD_W-1:0]     sad_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [CMP_W-1:0]     num_reg;
    logic [CMP_W-1:0]     den100_reg;
    logic [CMP_W-1:0]     dsh_reg;
    logic [CMP_W-1:0]     rem_reg;
    logic [Q_W-1:0]       q_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SCORE_W-1:0]   prev_md_reg;
    logic                 have_prev_reg;
    result_t              res_reg;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic [CMPC_W-1:0]     cnt_wide;
    logic [CMPC_W-1:0]     cnt_limit;
    logic [CMPC_W-1:0]     cnt_clamp;
    logic [BITS_CFG_W-1:0] shamt;
    logic [DEN_W-1:0]      den;
    logic                  saturate;
    logic [CMP_W:0]        rem_sh;
    logic [CMP_W:0]        dsh_ext;
    logic                  q_bit;
    logic [MW-1:0]         mafd_ext;
    logic [MW-1:0]         prev_ext;
    logic [MW-1:0]         diff;
    logic [MW-1:0]         score_raw;
    logic [MW-1:0]         score_clip;
    logic                  change;
    logic                  div_done;
    logic                  ld_out;

    // frame size clamp and denominator
    always_comb
    begin
        cnt_wide  = CMPC_W'(cfg.sample_count);
        cnt_limit = CMPC_W'(1) << COUNT_BITS;
        if (cnt_wide == '0)
        begin
            cnt_clamp = CMPC_W'(1);
        end
        else if (cnt_wide > cnt_limit)
        begin
            cnt_clamp = cnt_limit;
        end
        else
        begin
            cnt_clamp = cnt_wide;
        end
        if (cfg.sample_bits < MIN_BITS)
        begin
            shamt = MIN_BITS;
        end
        else if (cfg.sample_bits > MAX_BITS)
        begin
            shamt = MAX_BITS;
        end
        else
        begin
            shamt = cfg.sample_bits;
        end
        den = DEN_W'(cnt_clamp[CNT_W-1:0]) << shamt;
    end

    // one quotient bit per cycle
    always_comb
    begin
        saturate = num_reg >= den100_reg;
        rem_sh   = {rem_reg, 1'b0};
        dsh_ext  = {1'b0, dsh_reg};
        q_bit    = rem_sh >= dsh_ext;
        div_done = step_reg == STEP_W'(1);
    end

    // score against previous frame
    always_comb
    begin
        mafd_ext = MW'(q_reg);
        prev_ext = MW'(prev_md_reg);
        if (mafd_ext >= prev_ext)
        begin
            diff = mafd_ext - prev_ext;
        end
        else
        begin
            diff = prev_ext - mafd_ext;
        end
        score_raw  = (mafd_ext < diff) ? mafd_ext : diff;
        score_clip = (score_raw > MW'(HUNDRED_Q)) ? MW'(HUNDRED_Q) : score_raw;
        change     = score_clip >= MW'(cfg.threshold);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = have_prev_reg ? S_SCALE : S_SCORE;
                end
            end
            S_SCALE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = saturate ? S_SCORE : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        pop    = 1'b0;
        ld_out = 1'b0;
        unique case (state_reg)
            S_IDLE:  pop    = head_valid;
            S_EMIT:  ld_out = !out_valid_reg || results.ready;
            default:
            begin
                pop    = 1'b0;
                ld_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sad_reg <= head_sad;
                den_reg <= den;
            end
            S_SCALE:
            begin
                num_reg    <= (CMP_W'(sad_reg) << 6) + (CMP_W'(sad_reg) << 5)
                            + (CMP_W'(sad_reg) << 2);
                den100_reg <= (CMP_W'(den_reg) << 6) + (CMP_W'(den_reg) << 5)
                            + (CMP_W'(den_reg) << 2);
                dsh_reg    <= CMP_W'(den_reg) << 7;
            end
            S_CHECK:
            begin
                rem_reg  <= num_reg;
                step_reg <= STEP_W'(Q_W);
                q_reg    <= saturate ? HUNDRED_Q : '0;
            end
            S_DIV:
            begin
                rem_reg  <= q_bit ? CMP_W'(rem_sh - dsh_ext) : rem_sh[CMP_W-1:0];
                q_reg    <= {q_reg[Q_W-2:0], q_bit};
                step_reg <= step_reg - STEP_W'(1);
            end
            S_SCORE:
            begin
                if (have_prev_reg)
                begin
                    res_reg.mean_diff    <= mafd_ext[SCORE_W-1:0];
                    res_reg.score        <= score_clip[SCORE_W-1:0];
                    res_reg.scene_change <= change;
                    res_reg.keep_frame   <= cfg.pass_only_changes ? change : 1'b1;
                end
                else
                begin
                    res_reg.mean_diff    <= prev_md_reg;
                    res_reg.score        <= '0;
                    res_reg.scene_change <= cfg.threshold == '0;
                    res_reg.keep_frame   <= cfg.pass_only_changes ?
                                            (cfg.threshold == '0) : 1'b1;
                end
            end
            S_EMIT:
            begin
                if (ld_out)
                begin
                    out_reg <= res_reg;
                end
            end
            default:
            begin
                sad_reg <= sad_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_md_reg   <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_SCORE)
            begin
                if (have_prev_reg)
                begin
                    prev_md_reg <= mafd_ext[SCORE_W-1:0];
                end
                have_prev_reg <= 1'b1;
            end
            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule
